// ===== hw/rtl/xfse_pkg.sv =====
package xfse_pkg;

  localparam int WORD_W   = 64;
  localparam int LEAD_W   = 5;
  localparam int TRAIL_W  = 6;
  localparam int LZC_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 2 * WORD_W;
  localparam int PEND_W   = BYTE_W - 1;
  localparam int BUF_W    = CODE_W + PEND_W;
  localparam int CNT_W    = 8;
  localparam int LEAD_MAX = (1 << LEAD_W) - 1;

  typedef struct packed {
    logic [WORD_W-1:0] sample_bits;
    logic [WORD_W-1:0] block_count;
    logic              first;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_run;
  } out_word_t;

  // Leading zeros of one byte; only meaningful when the byte is nonzero.
  function automatic logic [2:0] lzc8(input logic [7:0] b);
    logic [2:0] n;
    logic       found;
    n     = 3'd0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && b[7-i]) begin
        n     = 3'(i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Leading zeros of a 64-bit word as a two-level tree: per-byte counts,
  // then a pick of the first nonzero byte. Returns 64 for a zero word.
  function automatic logic [LZC_W-1:0] lzc64(input logic [WORD_W-1:0] x);
    logic [LZC_W-1:0] n;
    logic             found;
    logic [7:0]       b;
    n     = LZC_W'(WORD_W);
    found = 1'b0;
    for (int i = 0; i < WORD_W / 8; i++) begin
      b = x[WORD_W-1-8*i -: 8];
      if (!found && (b != 8'd0)) begin
        n     = {1'b0, 3'(i), lzc8(b)};
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [WORD_W-1:0] bit_rev64(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = x[WORD_W-1-i];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/xor_float_stream_encoder.sv =====
// An accepted word passes stages A, B and C and the byte packer; its first byte
// leaves from the output register. Throughput: one output byte per cycle while
// the receiver does not stall; a word produces up to 11 bytes (17 for a block
// start), and words that add fewer than eight bits go through one per cycle.
// Reset (rst_n low, synchronous) empties all stages and clears the predictor.
module xor_float_stream_encoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  xfse_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output xfse_pkg::out_word_t  out_data
);

  // Kind of code produced for one sample.
  typedef enum logic [1:0] {
    K_FIRST = 2'd0,
    K_ZERO  = 2'd1,
    K_REUSE = 2'd2,
    K_NEW   = 2'd3
  } kind_t;

  localparam int W  = xfse_pkg::WORD_W;
  localparam int LW = xfse_pkg::LEAD_W;
  localparam int TW = xfse_pkg::TRAIL_W;
  localparam int CW = xfse_pkg::CODE_W;
  localparam int BW = xfse_pkg::BUF_W;
  localparam int NW = xfse_pkg::CNT_W;
  localparam int YW = xfse_pkg::BYTE_W;
  localparam int MW = TW + 1;  // meaningful length, 1..64

  // Stage handshake. Each stage takes a new word when it is empty or when
  // its current word moves on in the same cycle.
  logic a_take, b_take, c_take, load;

  // ---------------------------------------------------------------------
  // Stage A: input register.
  // ---------------------------------------------------------------------
  logic               a_v_r;
  xfse_pkg::in_word_t a_r;

  assign a_take   = !a_v_r || b_take;
  assign in_stall = !a_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_take) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && in_valid) begin
      a_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: XOR against the previous sample, count leading and trailing
  // zeros, and decide between the stored window and a new one. The
  // predictor state advances here, so the next sample sees it at once.
  // ---------------------------------------------------------------------
  logic [W-1:0]  prev_r;
  logic [LW-1:0] win_lead_r;
  logic [TW-1:0] win_trail_r;
  logic          win_v_r;

  logic [W-1:0]                 x_a;
  logic [xfse_pkg::LZC_W-1:0]   lz_a, tz_a;
  logic [LW-1:0]                lz_cl;
  logic [TW-1:0]                tz6;
  logic                         x_zero, reuse, b_move;
  kind_t                        kind_nxt;

  assign x_a    = prev_r ^ a_r.sample_bits;
  assign x_zero = (x_a == '0);
  assign lz_a   = xfse_pkg::lzc64(x_a);
  assign tz_a   = xfse_pkg::lzc64(xfse_pkg::bit_rev64(x_a));
  // The leading count is clamped so that it fits its five-bit field.
  assign lz_cl  = (lz_a > xfse_pkg::LZC_W'(xfse_pkg::LEAD_MAX)) ?
                  LW'(xfse_pkg::LEAD_MAX) : lz_a[LW-1:0];
  assign tz6    = tz_a[TW-1:0];
  assign reuse  = win_v_r && (lz_cl >= win_lead_r) && (tz6 >= win_trail_r);
  assign b_move = a_v_r && b_take;

  always_comb begin
    if (a_r.first) begin
      kind_nxt = K_FIRST;
    end else if (x_zero) begin
      kind_nxt = K_ZERO;
    end else if (reuse) begin
      kind_nxt = K_REUSE;
    end else begin
      kind_nxt = K_NEW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      win_lead_r  <= '0;
      win_trail_r <= '0;
      win_v_r     <= 1'b0;
    end else if (b_move) begin
      prev_r <= a_r.sample_bits;
      if (a_r.first) begin
        win_lead_r  <= '0;
        win_trail_r <= '0;
        win_v_r     <= 1'b0;
      end else if (!x_zero && !reuse) begin
        win_lead_r  <= lz_cl;
        win_trail_r <= tz6;
        win_v_r     <= 1'b1;
      end
    end
  end

  logic          b_v_r;
  kind_t         b_kind_r;
  logic [W-1:0]  b_x_r;
  logic [W-1:0]  b_count_r;
  logic [LW-1:0] b_lead_r;
  logic [TW-1:0] b_trail_r;
  logic          b_last_r;

  assign b_take = !b_v_r || c_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_take) begin
      b_v_r <= a_v_r;
    end
  end

  // For a block start the raw sample rides in b_x_r.
  always_ff @(posedge clk) begin
    if (b_move) begin
      b_kind_r  <= kind_nxt;
      b_x_r     <= a_r.first ? a_r.sample_bits : x_a;
      b_count_r <= a_r.block_count;
      b_lead_r  <= reuse ? win_lead_r : lz_cl;
      b_trail_r <= reuse ? win_trail_r : tz6;
      b_last_r  <= a_r.last;
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: build the code left-aligned in a 128-bit word with its length.
  // Shifting the XOR left by the leading count puts the meaningful bits at
  // the top; the bits under them are zero because the trailing count never
  // exceeds the real number of trailing zeros.
  // ---------------------------------------------------------------------
  logic [MW-1:0] len_m;
  logic [W-1:0]  xs;
  logic [CW-1:0] code_nxt;
  logic [NW-1:0] clen_nxt;
  logic          c_move;

  assign len_m  = MW'(MW'(W) - MW'(b_lead_r) - MW'(b_trail_r));
  assign xs     = b_x_r << b_lead_r;
  assign c_move = b_v_r && c_take;

  always_comb begin
    case (b_kind_r)
      K_FIRST: begin
        code_nxt = {b_count_r, b_x_r};
        clen_nxt = NW'(CW);
      end
      K_ZERO: begin
        code_nxt = '0;
        clen_nxt = NW'(1);
      end
      K_REUSE: begin
        code_nxt = {2'b10, xs, {(CW - W - 2){1'b0}}};
        clen_nxt = NW'(len_m) + NW'(2);
      end
      K_NEW: begin
        code_nxt = {2'b11, b_lead_r, TW'(len_m - MW'(1)), xs,
                    {(CW - W - 2 - LW - TW){1'b0}}};
        clen_nxt = NW'(len_m) + NW'(2 + LW + TW);
      end
      default: begin
        code_nxt = '0;
        clen_nxt = '0;
      end
    endcase
  end

  logic          c_v_r;
  logic [CW-1:0] c_code_r;
  logic [NW-1:0] c_len_r;
  logic          c_last_r;

  assign c_take = !c_v_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_take) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_move) begin
      c_code_r <= code_nxt;
      c_len_r  <= clen_nxt;
      c_last_r <= b_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Byte packer. The buffer holds the bits not yet sent, left-aligned, with
  // zeros below the count. A full byte leaves from the top each cycle the
  // output register can take one. Once fewer than eight bits remain (and a
  // flush, if asked for, has gone out) the next code is merged in right
  // after the leftover bits, possibly in the same cycle as the last byte.
  // ---------------------------------------------------------------------
  logic [BW-1:0] s_buf_r, s_buf_nxt, rem_buf;
  logic [NW-1:0] s_cnt_r, s_cnt_nxt, rem_cnt;
  logic          s_last_r, s_last_nxt, rem_last;
  logic          full_byte, emit_want, emit, out_free, done, eor;

  logic            out_valid_r;
  xfse_pkg::out_word_t out_r;

  assign full_byte = (s_cnt_r >= NW'(YW));
  assign emit_want = full_byte || (s_last_r && (s_cnt_r != '0));
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = emit_want && out_free;

  assign rem_cnt  = emit ? (full_byte ? s_cnt_r - NW'(YW) : '0) : s_cnt_r;
  assign rem_buf  = emit ? (s_buf_r << YW) : s_buf_r;
  assign rem_last = (emit && !full_byte) ? 1'b0 : s_last_r;
  assign done     = (rem_cnt < NW'(YW)) && !(rem_last && (rem_cnt != '0));
  assign load     = done && c_v_r;

  // This byte closes its word's output unless more full bytes or a flush
  // byte still follow. A flush byte always closes it.
  assign eor = full_byte ?
               ((s_cnt_r < NW'(2 * YW)) && !(s_last_r && (s_cnt_r != NW'(YW)))) :
               1'b1;

  always_comb begin
    if (load) begin
      s_buf_nxt  = rem_buf | ({c_code_r, {(BW - CW){1'b0}}} >> rem_cnt[2:0]);
      s_cnt_nxt  = rem_cnt + c_len_r;
      s_last_nxt = c_last_r;
    end else begin
      s_buf_nxt  = rem_buf;
      s_cnt_nxt  = rem_cnt;
      s_last_nxt = rem_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_buf_r  <= '0;
      s_cnt_r  <= '0;
      s_last_r <= 1'b0;
    end else begin
      s_buf_r  <= s_buf_nxt;
      s_cnt_r  <= s_cnt_nxt;
      s_last_r <= s_last_nxt;
    end
  end

  // Output register: holds a byte until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.out_byte   <= s_buf_r[BW-1 -: YW];
      out_r.end_of_run <= eor;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/xfse_checker.sv =====
module xfse_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input xfse_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input xfse_pkg::out_word_t out_data
);

  // A stalled input word stays and does not change.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input word changed or dropped while stalled");

  // A stalled output word stays and does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed or dropped while stalled");

  // Reset empties the output register.
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Reset empties the input register, so the input is open right after it.
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // No word can reach the output in the first cycles after reset.
  a_min_latency: assert property (@(posedge clk)
    !rst_n ##1 rst_n ##1 rst_n |=> !out_valid)
    else $error("output word earlier than the pipeline depth allows");

endmodule

bind xor_float_stream_encoder xfse_checker u_xfse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/xfse_stream_check.sv =====
`timescale 1ns / 100ps

module xfse_stream_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  xfse_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  xfse_pkg::out_word_t out_data,
  output int                  fail_count,
  output int                  bytes_owed
);

  // Encoder state as the stream sees it.
  logic [63:0] prev_sample;
  logic [4:0]  win_lead;
  logic [6:0]  win_trail;
  logic        win_ok;
  logic [6:0]  spare_bits;
  logic [2:0]  spare_count;

  xfse_pkg::out_word_t expected_bytes[$];

  // Appends one predicted byte; the caller marks the end of its word later.
  function automatic void queue_byte(input logic [7:0] b);
    xfse_pkg::out_word_t item;
    item.out_byte   = b;
    item.end_of_run = 1'b0;
    expected_bytes  = {expected_bytes, item};
  endfunction

  function automatic void shift_in(input logic b);
    logic [7:0] full;
    full = {spare_bits, b};
    if (spare_count == 3'd7) begin
      queue_byte(full);
      spare_bits  = '0;
      spare_count = '0;
    end else begin
      spare_bits  = full[6:0];
      spare_count = spare_count + 3'd1;
    end
  endfunction

  function automatic void shift_field(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      shift_in(v[i]);
    end
  endfunction

  function automatic void encode_sample(input xfse_pkg::in_word_t w);
    logic [63:0] diff;
    logic [7:0]  pad;
    int          lead;
    int          trail;
    int          span;
    int          start_size;
    start_size = expected_bytes.size();
    if (w.first) begin
      shift_field(w.block_count, 64);
      shift_field(w.sample_bits, 64);
      win_ok    = 1'b0;
      win_lead  = '0;
      win_trail = '0;
    end else begin
      diff = prev_sample ^ w.sample_bits;
      if (diff == '0) begin
        shift_in(1'b0);
      end else begin
        lead = 0;
        while (!diff[63 - lead]) lead++;
        trail = 0;
        while (!diff[trail]) trail++;
        shift_in(1'b1);
        if (lead > 31) lead = 31;
        if (win_ok && lead >= int'(win_lead) && trail >= int'(win_trail)) begin
          // Reuse the stored window: only its bits go out.
          span = 64 - int'(win_lead) - int'(win_trail[5:0]);
          shift_in(1'b0);
          shift_field(diff >> win_trail[5:0], span);
        end else begin
          span = 64 - lead - trail;
          shift_in(1'b1);
          shift_field(64'(lead), 5);
          shift_field(64'(span - 1), 6);
          shift_field(diff >> trail, span);
          win_lead  = 5'(lead);
          win_trail = 7'(trail);
          win_ok    = 1'b1;
        end
      end
    end
    prev_sample = w.sample_bits;
    if (w.last && spare_count != '0) begin
      pad = 8'({1'b0, spare_bits} << (8 - int'(spare_count)));
      queue_byte(pad);
      spare_bits  = '0;
      spare_count = '0;
    end
    if (expected_bytes.size() > start_size) begin
      expected_bytes[expected_bytes.size() - 1].end_of_run = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : monitor
    xfse_pkg::out_word_t want;
    if (!rst_n) begin
      prev_sample = '0;
      win_lead    = '0;
      win_trail   = '0;
      win_ok      = 1'b0;
      spare_bits  = '0;
      spare_count = '0;
      expected_bytes.delete();
    end else begin
      if (in_valid && !in_stall) begin
        encode_sample(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected byte, expected none, got %02h end_of_run %0b",
                   $time, out_data.out_byte, out_data.end_of_run);
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte ||
              out_data.end_of_run !== want.end_of_run) begin
            fail_count++;
            $display("%0t: byte mismatch, expected %02h end_of_run %0b, got %02h end_of_run %0b",
                     $time, want.out_byte, want.end_of_run,
                     out_data.out_byte, out_data.end_of_run);
          end
        end
      end
    end
    bytes_owed <= expected_bytes.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  // Total words offered, directed part included.
  localparam int TOTAL_WORDS    = 350;
  // Cycles the receiver refuses bytes in one stretch, long enough for the
  // encoder to fill all its stages and stall the sender.
  localparam int SQUEEZE_CYCLES = 400;
  // Cycles in a row with no word moving on either channel before we give up.
  localparam int IDLE_LIMIT     = 4000;
  // The encoder shows a byte only after its word has passed all stages; wait a good
  // deal longer than that after the last expected byte for stray output.
  localparam int DRAIN_CYCLES   = 16;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  xfse_pkg::in_word_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  xfse_pkg::out_word_t out_data;

  int fail_count;
  int bytes_owed;

  // Calm phases turn idling off on one side so that both channels also see
  // long back-to-back stretches.
  bit calm_in      = 1'b0;
  bit calm_out     = 1'b0;
  bit squeeze_req  = 1'b0;
  bit squeeze_done = 1'b0;
  int words_sent   = 0;

  always #2 clk = ~clk;

  xor_float_stream_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The checker watches both channels on its own, predicts every byte and
  // counts failures; this module only drives stimulus and gives the verdict.
  xfse_stream_check stream_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .bytes_owed (bytes_owed)
  );

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A plausible double: exponent near one, mantissa with a random number of
  // trailing zeros so that windows of many widths show up.
  function automatic logic [63:0] float_like();
    logic [63:0] mant;
    mant = rand64() & ~((64'd1 << $urandom_range(0, 48)) - 64'd1);
    return {1'($urandom), 11'($urandom_range(1000, 1050)), mant[51:0]};
  endfunction

  // Next sample of a series. Repeats give a zero difference, small changes
  // in the low mantissa bits tend to land inside the stored window, and the
  // rest often forces a new window, frequently a wide one.
  function automatic logic [63:0] next_sample(input logic [63:0] prev);
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return prev;
    if (r < 60) return prev ^ (rand64() & ((64'd1 << $urandom_range(1, 52)) - 64'd1));
    if (r < 75) return prev ^ (64'd1 << $urandom_range(0, 63));
    if (r < 85) return rand64();
    return float_like();
  endfunction

  // Offers one word at a falling edge, after an optional gap, and returns
  // once the encoder has taken it at a rising edge. Valid stays high from
  // one word to the next when there is no gap.
  task automatic send_word(input xfse_pkg::in_word_t w);
    int gap;
    gap = pick_gap(calm_in);
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_fields(input logic [63:0] sample, input logic [63:0] count,
                             input logic first, input logic last);
    xfse_pkg::in_word_t w;
    w.sample_bits = sample;
    w.block_count = count;
    w.first       = first;
    w.last        = last;
    send_word(w);
  endtask

  // One well-formed block: a header word with the count, the rest of the
  // series, and a flush on the final word. The count is sometimes arbitrary,
  // since the encoder only passes it through.
  task automatic send_block();
    int                 block_len;
    logic [63:0]        value;
    xfse_pkg::in_word_t w;
    block_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    value = float_like();
    w.sample_bits = value;
    w.block_count = ($urandom_range(0, 3) == 0) ? rand64() : 64'(block_len);
    w.first       = 1'b1;
    w.last        = (block_len == 1);
    send_word(w);
    for (int i = 1; i < block_len; i++) begin
      value = next_sample(value);
      w.sample_bits = value;
      w.block_count = rand64();
      w.first       = 1'b0;
      w.last        = (i == block_len - 1);
      send_word(w);
    end
  endtask

  initial begin : stimulus
    int                 next_phase;
    xfse_pkg::in_word_t w;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Right after reset a sample comes without a block start:
    // it is compared with an all-zero previous word and there is no window.
    // A zero difference adds one bit and produces no byte.
    send_fields(64'h0, 64'h0, 1'b0, 1'b0);
    // Difference of one: the leading count of 63 is clamped to 31.
    send_fields(64'h1, 64'h0, 1'b0, 1'b0);
    // Fits the window just stored.
    send_fields(64'h3, 64'h0, 1'b0, 1'b0);
    // Only the top bit differs: a new one-bit window at the very top.
    send_fields(64'h8000_0000_0000_0003, 64'h0, 1'b0, 1'b0);
    send_fields(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b1);
    // Block start with the smallest fields; its 128 bits end on a byte
    // boundary, so the flush finds nothing pending.
    send_fields(64'h0, 64'h0, 1'b1, 1'b1);
    // Leave one bit pending, then start a block with the largest fields:
    // the header must follow that bit without a break.
    send_fields(64'h0, 64'h0, 1'b0, 1'b0);
    send_fields(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    // Special values: infinity, NaN, negative zero, zero, smallest subnormal.
    send_fields(64'h7FF0_0000_0000_0000, 64'h0, 1'b0, 1'b0);
    send_fields(64'h7FF8_0000_0000_0000, 64'h0, 1'b0, 1'b0);
    send_fields(64'h8000_0000_0000_0000, 64'h0, 1'b0, 1'b0);
    send_fields(64'h0, 64'h0, 1'b0, 1'b0);
    send_fields(64'h1, 64'h0, 1'b0, 1'b0);
    send_fields(64'h1, 64'h0, 1'b0, 1'b1);
    // A block of a single word, then a short series around two.
    send_fields(64'h3FF0_0000_0000_0000, 64'h1, 1'b1, 1'b1);
    send_fields(64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
    send_fields(64'h4000_0000_0000_0001, 64'h0, 1'b0, 1'b0);
    send_fields(64'h4000_0000_0000_0003, 64'h0, 1'b0, 1'b0);
    send_fields(64'h4000_0000_0000_0002, 64'h0, 1'b0, 1'b0);
    send_fields(64'hC000_0000_0000_0000, 64'h0, 1'b0, 1'b1);
    // A lone repeated sample with a flush: a single all-zero padded byte.
    send_fields(64'hC000_0000_0000_0000, 64'h0, 1'b0, 1'b1);

    // Random part. It opens with the sender offering back to back while the
    // receiver holds off, so the encoder fills up and stalls its input.
    calm_in     = 1'b1;
    squeeze_req = 1'b1;
    next_phase  = words_sent + 40;
    while (words_sent < TOTAL_WORDS) begin
      if (words_sent >= next_phase) begin
        calm_in    = ($urandom_range(0, 3) == 0);
        calm_out   = ($urandom_range(0, 3) == 0);
        next_phase = words_sent + 50;
      end
      if ($urandom_range(0, 99) < 15) begin
        // Noise: flags and fields at random, including blocks left open,
        // stray flushes and block starts over unflushed bits.
        repeat ($urandom_range(1, 3)) begin
          w = {rand64(), rand64(), 1'($urandom), 1'($urandom)};
          send_word(w);
        end
      end else begin
        send_block();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Wait for every predicted byte, then a little longer for stray ones.
    wait (bytes_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("xor_float_stream_encoder verification clean");
    end else begin
      $display("xor_float_stream_encoder verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin : receiver
    int hold;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
      end else begin
        hold = pick_gap(calm_out);
        out_stall <= (hold > 0);
        if (hold > 1) begin
          repeat (hold - 1) @(negedge clk);
        end
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("xor_float_stream_encoder verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/xfse_pkg.sv
hw/rtl/xor_float_stream_encoder.sv
hw/rtl/xfse_checker.sv
test/xfse_stream_check.sv
test/tb.sv
